### rtl/kta_pkg.sv
// shared types, constants and key code tables for the keycode to ascii fifo
// no dependencies; used by kta_decode and keycode_to_ascii_fifo by scoped names
`default_nettype none

package kta_pkg;

  // default queue depth, one slot always stays unused
  localparam int unsigned FifoSlotsDefault = 32;

  localparam int unsigned CharW = 8;
  localparam int unsigned FillW = 5;

  // request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;

  localparam logic [7:0] KEY_TABLE_LEN = 8'd101;
  localparam logic [7:0] CODE_LSHIFT   = 8'hE1;
  localparam logic [7:0] CODE_RSHIFT   = 8'hE6;
  localparam logic [7:0] NO_CHAR       = 8'hFF;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] event_byte;
  } in_req_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             char_valid;
    logic [FillW-1:0] fill_count;
  } out_res_t;

  // character push from the key decoder
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] ch;
  } push_t;

  function automatic logic [7:0] plain_char(logic [7:0] code);
    logic [7:0] ch;
    ch = NO_CHAR;
    if (code >= 8'd4 && code <= 8'd29) begin
      ch = 8'h61 + (code - 8'd4);
    end else if (code >= 8'd30 && code <= 8'd38) begin
      ch = 8'h31 + (code - 8'd30);
    end else if (code >= 8'd89 && code <= 8'd97) begin
      ch = 8'h31 + (code - 8'd89);
    end else begin
      case (code)
        8'd39:   ch = 8'h30;
        8'd40:   ch = 8'h0A;
        8'd41:   ch = 8'h1B;
        8'd42:   ch = 8'h7F;
        8'd43:   ch = 8'h09;
        8'd44:   ch = 8'h20;
        8'd45:   ch = 8'h2D;
        8'd46:   ch = 8'h3D;
        8'd47:   ch = 8'h5B;
        8'd48:   ch = 8'h5D;
        8'd49:   ch = 8'h5C;
        8'd51:   ch = 8'h3B;
        8'd52:   ch = 8'h27;
        8'd53:   ch = 8'h60;
        8'd54:   ch = 8'h2C;
        8'd55:   ch = 8'h2E;
        8'd56:   ch = 8'h2F;
        8'd85:   ch = 8'h2A;
        8'd86:   ch = 8'h2D;
        8'd87:   ch = 8'h2B;
        8'd88:   ch = 8'h0A;
        8'd98:   ch = 8'h30;
        8'd99:   ch = 8'h2E;
        8'd100:  ch = 8'hA7;
        default: ch = NO_CHAR;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] shift_char(logic [7:0] code);
    logic [7:0] ch;
    ch = NO_CHAR;
    if (code >= 8'd4 && code <= 8'd29) begin
      ch = 8'h41 + (code - 8'd4);
    end else if (code >= 8'd89 && code <= 8'd97) begin
      ch = 8'h31 + (code - 8'd89);
    end else begin
      case (code)
        8'd30:   ch = 8'h21;
        8'd31:   ch = 8'h40;
        8'd32:   ch = 8'h23;
        8'd33:   ch = 8'h24;
        8'd34:   ch = 8'h25;
        8'd35:   ch = 8'h5E;
        8'd36:   ch = 8'h26;
        8'd37:   ch = 8'h2A;
        8'd38:   ch = 8'h28;
        8'd39:   ch = 8'h29;
        8'd40:   ch = 8'h0A;
        8'd41:   ch = 8'h1B;
        8'd42:   ch = 8'h7F;
        8'd43:   ch = 8'h09;
        8'd44:   ch = 8'h20;
        8'd45:   ch = 8'h5F;
        8'd46:   ch = 8'h2B;
        8'd47:   ch = 8'h7B;
        8'd48:   ch = 8'h7D;
        8'd49:   ch = 8'h7C;
        8'd51:   ch = 8'h3A;
        8'd52:   ch = 8'h22;
        8'd53:   ch = 8'h7E;
        8'd54:   ch = 8'h3C;
        8'd55:   ch = 8'h3E;
        8'd56:   ch = 8'h3F;
        8'd85:   ch = 8'h2A;
        8'd86:   ch = 8'h2D;
        8'd87:   ch = 8'h2B;
        8'd88:   ch = 8'h0A;
        8'd98:   ch = 8'h30;
        8'd99:   ch = 8'h2E;
        8'd100:  ch = 8'hB1;
        default: ch = NO_CHAR;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/kta_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module kta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/kta_decode.sv
// key event decoder: pairs code and state bytes, tracks shift keys,
// translates pressed keys to characters; depends on kta_pkg
`default_nettype none

module kta_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               byte_valid_i,
  input  wire logic [7:0]         byte_i,
  output kta_pkg::push_t          push_o
);

  logic       awaiting_q, awaiting_d;
  logic [7:0] held_q, held_d;
  logic       lshift_q, lshift_d;
  logic       rshift_q, rshift_d;
  logic [7:0] ch;

  assign ch = (lshift_q || rshift_q) ? kta_pkg::shift_char(held_q)
                                     : kta_pkg::plain_char(held_q);

  always_comb begin
    awaiting_d   = awaiting_q;
    held_d       = held_q;
    lshift_d     = lshift_q;
    rshift_d     = rshift_q;
    push_o.valid = 1'b0;
    push_o.ch    = ch;
    if (byte_valid_i) begin
      if (!awaiting_q) begin
        if (byte_i < kta_pkg::KEY_TABLE_LEN || byte_i == kta_pkg::CODE_LSHIFT ||
            byte_i == kta_pkg::CODE_RSHIFT) begin
          awaiting_d = 1'b1;
          held_d     = byte_i;
        end
      end else begin
        awaiting_d = 1'b0;
        if (held_q == kta_pkg::CODE_LSHIFT) begin
          lshift_d = (byte_i != 8'd0);
        end else if (held_q == kta_pkg::CODE_RSHIFT) begin
          rshift_d = (byte_i != 8'd0);
        end else if (byte_i != 8'd0 && held_q < kta_pkg::KEY_TABLE_LEN) begin
          push_o.valid = (ch != kta_pkg::NO_CHAR);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      held_q     <= 8'd0;
      lshift_q   <= 1'b0;
      rshift_q   <= 1'b0;
    end else begin
      awaiting_q <= awaiting_d;
      held_q     <= held_d;
      lshift_q   <= lshift_d;
      rshift_q   <= rshift_d;
    end
  end

endmodule

`default_nettype wire

### rtl/keycode_to_ascii_fifo.sv
// Keyboard event byte stream to ASCII character queue.
// Input channel (in_valid_i / in_stall_o) carries one request: mode and
// event_byte. Mode write feeds a byte to the key decoder (code, then state);
// pressed keys are translated and pushed into a ring queue held in a
// synchronous ram of FIFO_SLOTS entries, at most FIFO_SLOTS-1 characters.
// Modes pop and peek read the queue head; every request yields exactly one
// result on the output channel (out_valid_o / out_stall_i) with the
// character, its valid flag and the fill count after the request.
// A write, an unused mode and a pop or peek on an empty queue are answered
// from the output register in the cycle after they are taken; a pop or peek
// that finds a character goes through ST_READ, which loads the registered
// ram read data. One request is in flight at a time: one request per cycle
// while out_stall_i is low, but a read that hits stalls input in ST_READ.
// Reset clears pointers, shift flags and the decoder, leaving an empty queue;
// ram contents are not cleared. While the receiver stalls a waiting result,
// in_stall_o stays high and no request is taken.
`default_nettype none

module keycode_to_ascii_fifo #(
  parameter int unsigned FIFO_SLOTS = kta_pkg::FifoSlotsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire kta_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output kta_pkg::out_res_t      out_res_o
);

  localparam int unsigned PtrW = $clog2(FIFO_SLOTS);
  localparam int unsigned ExtW = (PtrW > kta_pkg::FillW) ? PtrW : kta_pkg::FillW;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(FIFO_SLOTS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_q, state_d;
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW-1:0]  wr_nxt, rd_nxt;
  logic             pop_q;
  logic             out_valid_q, out_valid_d;
  kta_pkg::out_res_t out_q, out_d;
  logic             load;
  logic             out_free, accept, is_write, is_rd, full;
  logic [7:0]       rdata;
  kta_pkg::push_t   push;
  logic [PtrW:0]    fill_wide;
  logic [PtrW-1:0]  fill;
  logic [ExtW-1:0]  fill_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_READ) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_write   = accept && (in_req_i.mode == kta_pkg::MODE_WRITE);
  assign is_rd      = accept && (wr_q != rd_q) &&
                      (in_req_i.mode == kta_pkg::MODE_POP ||
                       in_req_i.mode == kta_pkg::MODE_PEEK);

  assign wr_nxt = (wr_q == LastSlot) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == LastSlot) ? '0 : rd_q + 1'b1;
  assign full   = (wr_nxt == rd_q);

  kta_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(is_write),
    .byte_i      (in_req_i.event_byte),
    .push_o      (push)
  );

  kta_ram #(
    .Width(kta_pkg::CharW),
    .Depth(FIFO_SLOTS),
    .AddrW(PtrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push.valid && !full),
    .waddr_i(wr_q),
    .wdata_i(push.ch),
    .re_i   (is_rd),
    .raddr_i(rd_q),
    .rdata_o(rdata)
  );

  // fill level after this request, wrapping for any slot count
  always_comb begin
    if (wr_d >= rd_d) begin
      fill_wide = {1'b0, wr_d} - {1'b0, rd_d};
    end else begin
      fill_wide = {1'b0, wr_d} + (PtrW + 1)'(FIFO_SLOTS) - {1'b0, rd_d};
    end
    fill     = fill_wide[PtrW-1:0];
    fill_ext = ExtW'(fill);
  end

  always_comb begin
    state_d     = state_q;
    wr_d        = (push.valid && !full) ? wr_nxt : wr_q;
    rd_d        = rd_q;
    load        = 1'b0;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (is_rd) begin
          state_d = ST_READ;
        end else if (accept) begin
          load = 1'b1;
          out_d.char_out   = 8'd0;
          out_d.char_valid = 1'b0;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        load    = 1'b1;
        if (pop_q) begin
          rd_d = rd_nxt;
        end
        out_d.char_out   = rdata;
        out_d.char_valid = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    out_d.fill_count = fill_ext[kta_pkg::FillW-1:0];
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rd) begin
      pop_q <= (in_req_i.mode == kta_pkg::MODE_POP);
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire
